FILE: src/updec_pkg.sv
// Shared types, character codes and hex helpers for the URL percent decoder.
// No dependencies; used by the decoder core and its port checker.
package updec_pkg;

   localparam logic [7:0]  CHAR_PLUS     = 8'h2B;
   localparam logic [7:0]  CHAR_PCT      = 8'h25;
   localparam logic [7:0]  CHAR_SPACE    = 8'h20;
   localparam logic [15:0] MAX_OUT_RESET = 16'hFFFF;
   localparam int          MAX_RESULTS   = 4;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_PCT  = 3'b010,
      PH_HEX1 = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic [15:0] out_count;
      logic        run_last;
   } rsp_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

endpackage

FILE: src/url_percent_decoder_core.sv
// URL percent decoder (form style): one encoded byte in, up to four results out.
// Depends on updec_pkg for payload types, character codes and hex helpers.
//
// Takes one encoded byte per cycle when not stalled. An item is decoded in the
// cycle it is accepted and its results (zero to four: decoded bytes and, on the
// final byte, an end report with the count) land in a four-entry result queue
// that drains one result per cycle unless rsp_stall holds it. An item causing
// k results holds the input side until its last result is leaving the queue.
// The queue is the only limit on rate. max_out may be written only while idle.
module url_percent_decoder_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  updec_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output updec_pkg::rsp_type  rsp_data,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);
   import updec_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  digit_ff, digit_in;
   logic [15:0] count_ff, count_in;
   logic        limit_ff, limit_in;
   logic [15:0] max_out_ff;

   rsp_type     slot_ff [MAX_RESULTS];
   rsp_type     slot_in [MAX_RESULTS];
   logic [2:0]  fill_ff, fill_in;

   logic        accept, take;
   logic [7:0]  b;
   logic        fin;
   logic        b_hex;
   logic        idle_emit;
   logic        idle_open;
   logic [7:0]  idle_byte;
   logic [7:0]  cand [MAX_RESULTS];
   logic [1:0]  n_cand;
   logic [16:0] room;
   logic [1:0]  n_emit;
   logic [15:0] count_after;
   logic [2:0]  n_total;

   assign b    = req_data.in_byte;
   assign fin  = req_data.final_byte;
   assign b_hex = is_hex(b);

   assign rsp_valid = (fill_ff != 3'd0);
   assign rsp_data  = slot_ff[0];
   assign take      = rsp_valid && !rsp_stall;
   // accept only when the queue is empty or its last entry leaves this cycle
   assign req_stall = !((fill_ff == 3'd0) || ((fill_ff == 3'd1) && !rsp_stall));
   assign accept    = req_valid && !req_stall;

   // byte handled from idle; a final byte never opens an escape
   assign idle_open = (b == CHAR_PCT) && !fin;
   assign idle_emit = !idle_open;
   assign idle_byte = (b == CHAR_PLUS) ? CHAR_SPACE : b;

   always_comb begin
      cand[0]  = idle_byte;
      cand[1]  = 8'h00;
      cand[2]  = 8'h00;
      cand[3]  = 8'h00;
      n_cand   = {1'b0, idle_emit};
      phase_in = idle_open ? PH_PCT : PH_IDLE;
      digit_in = 8'h00;
      unique case (phase_ff)
         PH_PCT: begin
            if (b_hex && !fin) begin
               n_cand   = 2'd0;
               phase_in = PH_HEX1;
               digit_in = b;
            end else begin
               cand[0] = CHAR_PCT;
               cand[1] = idle_byte;
               n_cand  = 2'd1 + {1'b0, idle_emit};
            end
         end
         PH_HEX1: begin
            if (b_hex) begin
               cand[0]  = {hex_val(digit_ff), hex_val(b)};
               n_cand   = 2'd1;
               phase_in = PH_IDLE;
            end else begin
               cand[0] = CHAR_PCT;
               cand[1] = digit_ff;
               cand[2] = idle_byte;
               n_cand  = 2'd2 + {1'b0, idle_emit};
            end
         end
         default: begin
         end
      endcase
      if (fin) begin
         phase_in = PH_IDLE;
         digit_in = 8'h00;
      end
   end

   // how many candidates fit under the limit; they always form a prefix
   always_comb begin
      room = 17'd0;
      if (!limit_ff && (count_ff < max_out_ff)) begin
         room = {1'b0, max_out_ff} - {1'b0, count_ff};
      end
      n_emit      = (room >= {15'd0, n_cand}) ? n_cand : room[1:0];
      count_after = count_ff + {14'd0, n_emit};
      n_total     = {1'b0, n_emit} + {2'b00, fin};
      limit_in    = limit_ff || ((n_cand != 2'd0) && (count_after >= max_out_ff));
      count_in    = count_after;
      if (fin) begin
         count_in = 16'd0;
         limit_in = 1'b0;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         slot_in[k] = slot_ff[k];
      end
      if (accept) begin
         fill_in = n_total;
         for (int j = 0; j < MAX_RESULTS; j++) begin
            if (3'(j) < {1'b0, n_emit}) begin
               slot_in[j].kind      = KIND_DATA;
               slot_in[j].out_byte  = cand[j];
               slot_in[j].out_count = count_ff + 16'(j) + 16'd1;
            end else begin
               slot_in[j].kind      = KIND_END;
               slot_in[j].out_byte  = 8'h00;
               slot_in[j].out_count = count_after;
            end
            slot_in[j].run_last = (3'(j) + 3'd1 == n_total);
         end
      end else if (take) begin
         fill_in = fill_ff - 3'd1;
         for (int k = 0; k < MAX_RESULTS - 1; k++) begin
            slot_in[k] = slot_ff[k + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         digit_ff   <= 8'h00;
         count_ff   <= 16'd0;
         limit_ff   <= 1'b0;
         fill_ff    <= 3'd0;
         max_out_ff <= MAX_OUT_RESET;
      end else begin
         fill_ff <= fill_in;
         if (accept) begin
            phase_ff <= phase_in;
            digit_ff <= digit_in;
            count_ff <= count_in;
            limit_ff <= limit_in;
         end
         if (csr_wr_en) begin
            max_out_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         slot_ff[k] <= slot_in[k];
      end
   end

endmodule

FILE: src/updec_checker.sv
// Port-level checker for url_percent_decoder_core, bound to every instance.
// Depends on updec_pkg for payload types and result kind codes.
module updec_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input updec_pkg::req_type  req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input updec_pkg::rsp_type  rsp_data
);
   import updec_pkg::*;

   // a waiting result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // the results of one item come out without gaps
   a_run_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.run_last |=> rsp_valid)
      else $error("gap inside a result run");

   // no new item while more than the current result of a run is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.run_last |-> req_stall)
      else $error("item taken while a run is pending");

   // end report closes its run and carries no byte
   a_end_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_END |->
         rsp_data.run_last && rsp_data.out_byte == 8'h00)
      else $error("malformed end report");

   // a data byte always counts itself
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_DATA |-> rsp_data.out_count != 16'd0)
      else $error("data byte with zero count");

endmodule

bind url_percent_decoder_core updec_checker u_updec_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: sim/url_decoder_scoreboard.sv
`timescale 1ns / 1ps
// Port-level scoreboard for url_percent_decoder_core: predicts each item's results and compares.
// Depends on updec_pkg for payload types, character codes and the escape phase encoding.
module url_decoder_scoreboard (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  updec_pkg::req_type  req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  updec_pkg::rsp_type  rsp_data,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   output int                  mismatch_count,
   output int                  outstanding
);

   updec_pkg::phase_type esc_phase;
   logic [7:0]           held_digit;
   logic [15:0]          byte_cap;
   logic [15:0]          written;
   logic                 cap_reached;

   updec_pkg::rsp_type   decoded_queue[$];
   updec_pkg::rsp_type   step_out[updec_pkg::MAX_RESULTS];
   int                   step_n;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic logic hex_digit_ok(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   // digits map to their low nibble; both letter cases sit at low nibble 1..6
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      if (c <= "9") begin
         return c[3:0];
      end
      return c[3:0] + 4'd9;
   endfunction

   task automatic add_result(input logic kind, input logic [7:0] b);
      updec_pkg::rsp_type r;
      r.kind      = kind;
      r.out_byte  = b;
      r.out_count = written;
      r.run_last  = 1'b0;
      step_out[step_n] = r;
      step_n++;
   endtask

   task automatic put_byte(input logic [7:0] b);
      if (cap_reached || written >= byte_cap) begin
         cap_reached = 1'b1;
      end else begin
         written = written + 16'd1;
         add_result(updec_pkg::KIND_DATA, b);
         if (written >= byte_cap) begin
            cap_reached = 1'b1;
         end
      end
   endtask

   // a final byte never opens an escape
   task automatic from_idle(input logic [7:0] b, input logic fin);
      if (b == updec_pkg::CHAR_PLUS) begin
         put_byte(updec_pkg::CHAR_SPACE);
      end else if (b == updec_pkg::CHAR_PCT && !fin) begin
         esc_phase = updec_pkg::PH_PCT;
      end else begin
         put_byte(b);
      end
   endtask

   task automatic decode_step(input updec_pkg::req_type item);
      updec_pkg::phase_type was;
      logic [7:0]           b;
      logic                 fin;
      was       = esc_phase;
      b         = item.in_byte;
      fin       = item.final_byte;
      step_n    = 0;
      esc_phase = updec_pkg::PH_IDLE;
      case (was)
         updec_pkg::PH_PCT: begin
            if (hex_digit_ok(b) && !fin) begin
               held_digit = b;
               esc_phase  = updec_pkg::PH_HEX1;
            end else begin
               put_byte(updec_pkg::CHAR_PCT);
               from_idle(b, fin);
            end
         end
         updec_pkg::PH_HEX1: begin
            if (hex_digit_ok(b)) begin
               put_byte({hex_nibble(held_digit), hex_nibble(b)});
            end else begin
               put_byte(updec_pkg::CHAR_PCT);
               put_byte(held_digit);
               from_idle(b, fin);
            end
            held_digit = 8'h00;
         end
         default: begin
            from_idle(b, fin);
         end
      endcase
      if (fin) begin
         add_result(updec_pkg::KIND_END, 8'h00);
         esc_phase   = updec_pkg::PH_IDLE;
         held_digit  = 8'h00;
         written     = 16'd0;
         cap_reached = 1'b0;
      end
      if (step_n > 0) begin
         step_out[step_n - 1].run_last = 1'b1;
      end
      for (int i = 0; i < step_n; i++) begin
         decoded_queue.push_back(step_out[i]);
      end
   endtask

   task automatic report_bad(input string what, input updec_pkg::rsp_type want,
                             input updec_pkg::rsp_type got);
      if (mismatch_count < 10) begin
         $write("%0t: %s: expected kind=%0d byte=%02h count=%0d last=%0d,",
                $time, what, want.kind, want.out_byte, want.out_count, want.run_last);
         $display(" got kind=%0d byte=%02h count=%0d last=%0d",
                  got.kind, got.out_byte, got.out_count, got.run_last);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      updec_pkg::rsp_type want;
      if (reset) begin
         esc_phase   = updec_pkg::PH_IDLE;
         held_digit  = 8'h00;
         byte_cap    = updec_pkg::MAX_OUT_RESET;
         written     = 16'd0;
         cap_reached = 1'b0;
         decoded_queue.delete();
      end else begin
         if (csr_wr_en) begin
            byte_cap = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            decode_step(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_queue.size() == 0) begin
               want = '0;
               report_bad("result with none pending", want, rsp_data);
            end else begin
               want = decoded_queue.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.out_byte !== want.out_byte ||
                   rsp_data.out_count !== want.out_count ||
                   rsp_data.run_last !== want.run_last) begin
                  report_bad("result mismatch", want, rsp_data);
               end
            end
         end
      end
      outstanding = decoded_queue.size();
   end

endmodule

FILE: sim/url_percent_decoder_core_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for url_percent_decoder_core; checking is done by url_decoder_scoreboard.
// Depends on updec_pkg, the decoder core and the scoreboard module.
module url_percent_decoder_core_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 22;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   updec_pkg::req_type req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   updec_pkg::rsp_type rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [15:0]        csr_wr_data = 16'h0000;

   int mismatch_count;
   int outstanding;
   int cycle_count    = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   url_percent_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   url_decoder_scoreboard scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // holds the item until the edge that takes it; valid stays up for the next call
   task automatic send_byte(input logic [7:0] b, input logic fin);
      updec_pkg::req_type item;
      item.in_byte    = b;
      item.final_byte = fin;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_cap(input logic [15:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_text(input string s, input logic ends_string);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], ends_string && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) begin
         return 8'h30 + n;
      end
      return (upper ? 8'h37 : 8'h57) + n;
   endfunction

   function automatic logic [15:0] pick_cap();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'($urandom_range(2, 6));
         3: return 16'($urandom_range(0, 65535));
         default: return 16'hFFFF;
      endcase
   endfunction

   // mostly well-formed tokens, with some broken escapes and raw noise bytes
   task automatic send_random_string(input int tokens);
      logic [7:0] text[$];
      int         pick;
      int         cut;
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            text.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end else if (pick < 55) begin
            text.push_back(updec_pkg::CHAR_PLUS);
         end else if (pick < 85) begin
            text.push_back(updec_pkg::CHAR_PCT);
            text.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            text.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
         end else if (pick < 93) begin
            text.push_back(updec_pkg::CHAR_PCT);
            if ($urandom_range(1)) begin
               text.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
            text.push_back(8'($urandom_range(255)));
         end else begin
            text.push_back(8'($urandom_range(255)));
         end
      end
      // now and then set the cap to a small value partway through the string
      cut = ($urandom_range(7) == 0) ? $urandom_range(text.size() - 1) : -1;
      for (int i = 0; i < text.size(); i++) begin
         if (i == cut && i > 0) begin
            write_cap(16'($urandom_range(0, 3)));
         end
         send_byte(text[i], i == text.size() - 1);
      end
   endtask

   initial begin
      int phase_start;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: escapes of both cases, broken escapes, byte extremes, cut-off strings
      write_cap(16'hFFFF);
      send_text("+%4a%G%5z%%E1", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(updec_pkg::CHAR_PCT, 1'b1);
      send_text("%a", 1'b1);
      send_text("%4+", 1'b1);
      write_cap(16'd3);
      send_text("ab+c", 1'b1);
      write_cap(16'd0);
      send_text("x", 1'b1);
      write_cap(16'hFFFF);
      send_text("ab", 1'b0);
      write_cap(16'd1);
      send_text("c", 1'b1);

      for (int ph = 0; ph < 3; ph++) begin
         settle();
         send_idle_pct  = (ph == 0) ? 27 : (ph == 1) ? 60 : 0;
         recv_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 27 : 0;
         phase_start    = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(2) == 0) begin
               write_cap(pick_cap());
            end
            send_random_string($urandom_range(1, 8));
         end
      end

      settle();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
